// ===== hw/rtl/fsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared widths, register codes, token type and sine table builder for the
// sine series derivative evaluator.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int DEF_NUM_HARMONICS   = 4;
  localparam int DEF_MAX_ORDER       = 7;
  localparam int DEF_SINE_TABLE_BITS = 10;

  localparam int POS_W    = 32;
  localparam int ORDER_W  = 3;
  localparam int REG_W    = 32;
  localparam int RESULT_W = 64;
  localparam int ACC_W    = 66;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_CELLS = 4;
  localparam int TRIG_W   = 31;
  localparam int P1_W     = 63;
  localparam int KH_W     = 35;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_WAVENUMBER = 3'd0,
    REG_PHASE_STEP      = 3'd1,
    REG_HARMONIC_FIRST  = 3'd2,
    REG_HARMONIC_SECOND = 3'd3,
    REG_HARMONIC_THIRD  = 3'd4,
    REG_HARMONIC_FOURTH = 3'd5
  } cfg_reg_t;

  // item travelling down the row of cells with its running sum
  typedef struct packed {
    logic                    v;
    logic [POS_W-1:0]        pos;
    logic [ORDER_W-1:0]      order;
    logic signed [ACC_W-1:0] acc;
    logic                    over;
  } fsd_tok_t;

  // one table entry, nested polynomial in Q30, evaluated at elaboration
  function automatic logic [TRIG_W-1:0] sine_entry(input int i, input int tab_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] p;
    x  = (HALF_PI_Q30 * 64'(i)) >> tab_bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd156;
    for (int j = 0; j < 5; j++) begin
      p = (x2 * t) >> 30;
      case (j)
        0:       t = ONE_Q30 - p / 64'd110;
        1:       t = ONE_Q30 - p / 64'd72;
        2:       t = ONE_Q30 - p / 64'd42;
        3:       t = ONE_Q30 - p / 64'd20;
        default: t = ONE_Q30 - p / 64'd6;
      endcase
    end
    s = (x * t) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    return s[TRIG_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/fsd_if.sv =====
// ----------------------------------------------------------------------------
// fsd_in_if / fsd_out_if
// Valid/ready channels for positions in and derivative results out.
// ----------------------------------------------------------------------------
interface fsd_in_if import fsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   axial_position;
  logic [ORDER_W-1:0] derivative_order;
  modport source (output valid, axial_position, derivative_order, input ready);
  modport sink   (input valid, axial_position, derivative_order, output ready);
endinterface

interface fsd_out_if import fsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] field_derivative;
  logic                overflow;
  modport source (output valid, field_derivative, overflow, input ready);
  modport sink   (input valid, field_derivative, overflow, output ready);
endinterface

// ===== hw/rtl/fsd_cell.sv =====
// ----------------------------------------------------------------------------
// fsd_cell
// One harmonic: phase, table lookup, wavenumber power chain, term, running sum.
// ----------------------------------------------------------------------------
module fsd_cell import fsd_pkg::*; #(
  parameter int HARM            = 1,
  parameter int MAX_ORDER       = DEF_MAX_ORDER,
  parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [REG_W-1:0] base_wavenumber,
  input  logic [REG_W-1:0] phase_step,
  input  logic [REG_W-1:0] amplitude,
  input  fsd_tok_t         tok_i,
  output fsd_tok_t         tok_o
);

  localparam int MAX_STEPS = (1 << ORDER_W) - 1;
  localparam int PW    = (MAX_ORDER < MAX_STEPS) ? MAX_ORDER : MAX_STEPS;
  localparam int DEPTH = 7 + 2 * PW;
  localparam int TLEN  = (1 << SINE_TABLE_BITS) + 1;
  localparam int IDX_W = SINE_TABLE_BITS + 1;

  typedef struct packed {
    logic [63:0]     kp;
    logic            ksat;
    logic [P1_W-1:0] p1;
    logic            neg;
    logic [66:0]     pa;
    logic [66:0]     pb;
  } wk_t;

  fsd_tok_t          tok_r [DEPTH];
  fsd_tok_t          tok_last_nxt;
  logic [47:0]       pp_r;
  logic [31:0]       ph_r;
  logic [TRIG_W-1:0] smag_r;
  logic              sneg_r;
  wk_t               wk_r [2*PW+1];
  logic [63:0]       pll_r, plh_r;
  logic [62:0]       phl_r, phh_r;
  logic              p1nz_r, ksat_r, neg1_r;
  logic [63:0]       mag_r;
  logic              tover_r, neg2_r;

  logic [TRIG_W-1:0] rom [TLEN];
  logic [KH_W-1:0]   kh;
  logic [31:0]       amag;
  logic              aneg;
  logic signed [47:0] pp_full;
  logic [47:0]       ph_full;
  logic [31:0]       ph_nxt;
  logic [IDX_W-1:0]  idx;
  logic [126:0]      full;
  logic              tover_nxt;
  logic signed [ACC_W-1:0] term;

  for (genvar i = 0; i < TLEN; i++) begin : g_rom
    assign rom[i] = sine_entry(i, SINE_TABLE_BITS);
  end

  // only the low 48 bits of position times step reach the phase
  assign pp_full = $signed(tok_i.pos) * $signed({1'b0, phase_step});
  assign kh      = KH_W'(HARM) * {3'b0, base_wavenumber};
  assign aneg    = amplitude[REG_W-1];
  assign amag    = aneg ? (32'd0 - amplitude) : amplitude;
  assign ph_full = pp_r * 48'(HARM);
  assign ph_nxt  = ph_full[47:16] + (tok_r[0].order[0] ? 32'h4000_0000 : 32'h0);
  assign idx     = ph_r[30] ? (IDX_W'(1 << SINE_TABLE_BITS)
                              - {1'b0, ph_r[29 -: SINE_TABLE_BITS]})
                            : {1'b0, ph_r[29 -: SINE_TABLE_BITS]};

  // token shift line, running sum updated in the last stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DEPTH; s++) tok_r[s].v <= 1'b0;
    end else if (en) begin
      tok_r[0] <= tok_i;
      for (int s = 1; s < DEPTH - 1; s++) tok_r[s] <= tok_r[s-1];
      tok_r[DEPTH-1] <= tok_last_nxt;
    end
  end

  // phase, lookup and amplitude product
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r    <= pp_full;
      ph_r    <= ph_nxt;
      smag_r  <= rom[idx];
      sneg_r  <= ph_r[31];
      wk_r[0] <= '{kp:   64'd1 << 24,
                   ksat: 1'b0,
                   p1:   amag * {1'b0, smag_r},
                   neg:  aneg ^ sneg_r ^ tok_r[2].order[1],
                   pa:   '0,
                   pb:   '0};
    end
  end

  // wavenumber power chain, two stages per multiplication
  for (genvar j = 0; j < PW; j++) begin : g_pow
    logic [98:0] prod;
    logic        act;
    wk_t         mid_nxt;
    wk_t         end_nxt;
    assign prod = {32'b0, wk_r[2*j+1].pa} + {wk_r[2*j+1].pb, 32'b0};
    assign act  = (ORDER_W'(j) < tok_r[4+2*j].order) && !wk_r[2*j+1].ksat;
    always_comb begin
      mid_nxt    = wk_r[2*j];
      mid_nxt.pa = wk_r[2*j].kp[31:0] * kh;
      mid_nxt.pb = wk_r[2*j].kp[63:32] * kh;
      end_nxt    = wk_r[2*j+1];
      if (act) begin
        if (|prod[98:88]) end_nxt.ksat = 1'b1;
        else              end_nxt.kp   = prod[87:24];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        wk_r[2*j+1] <= mid_nxt;
        wk_r[2*j+2] <= end_nxt;
      end
    end
  end

  // term product, scaling and clamp
  assign full = {63'b0, pll_r} + {31'b0, plh_r, 32'b0} + {32'b0, phl_r, 32'b0}
              + {phh_r, 64'b0};
  assign tover_nxt = p1nz_r && (ksat_r || (|full[126:102]) || full[101]);

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r   <= wk_r[2*PW].p1[31:0]  * wk_r[2*PW].kp[31:0];
      plh_r   <= wk_r[2*PW].p1[31:0]  * wk_r[2*PW].kp[63:32];
      phl_r   <= wk_r[2*PW].p1[62:32] * wk_r[2*PW].kp[31:0];
      phh_r   <= wk_r[2*PW].p1[62:32] * wk_r[2*PW].kp[63:32];
      p1nz_r  <= |wk_r[2*PW].p1;
      ksat_r  <= wk_r[2*PW].ksat;
      neg1_r  <= wk_r[2*PW].neg;
      mag_r   <= tover_nxt ? 64'h7FFF_FFFF_FFFF_FFFF : full[101:38];
      tover_r <= tover_nxt;
      neg2_r  <= neg1_r;
    end
  end

  assign term = neg2_r ? -$signed({2'b0, mag_r}) : $signed({2'b0, mag_r});

  always_comb begin
    tok_last_nxt      = tok_r[DEPTH-2];
    tok_last_nxt.acc  = tok_r[DEPTH-2].acc + term;
    tok_last_nxt.over = tok_r[DEPTH-2].over | tover_r;
  end

  assign tok_o = tok_r[DEPTH-1];

endmodule

// ===== hw/rtl/fourier_series_derivative_core.sv =====
// ----------------------------------------------------------------------------
// fourier_series_derivative_core
// n-th axial derivative of a four-term sine series in fixed point.
// ----------------------------------------------------------------------------
// channel  | dir | transfer when      | payload
// in_chan  | in  | valid && ready     | axial_position Q16.16, derivative_order
// out_chan | out | valid && ready     | field_derivative Q32.32, overflow
// cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// one item per cycle while the row of cells advances; the depth of each cell is
// set by its wavenumber power chain (two stages per product)
// synchronous active-low reset clears config, valid bits and the output flag
// the row of cells advances whenever the output register is free, being
// drained, or the last cell holds a bubble; in_chan.ready follows that and
// stays low during reset
// ----------------------------------------------------------------------------
module fourier_series_derivative_core import fsd_pkg::*; #(
  parameter int NUM_HARMONICS   = DEF_NUM_HARMONICS,
  parameter int MAX_ORDER       = DEF_MAX_ORDER,
  parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fsd_in_if.sink               in_chan,
  fsd_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  // configuration registers
  logic [REG_W-1:0] base_wavenumber_r;
  logic [REG_W-1:0] phase_step_r;
  logic [REG_W-1:0] amp_r [MAX_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_wavenumber_r <= '0;
      phase_step_r      <= '0;
      for (int i = 0; i < MAX_CELLS; i++) amp_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_WAVENUMBER: base_wavenumber_r <= cfg_data;
        REG_PHASE_STEP:      phase_step_r      <= cfg_data;
        REG_HARMONIC_FIRST:  amp_r[0]          <= cfg_data;
        REG_HARMONIC_SECOND: amp_r[1]          <= cfg_data;
        REG_HARMONIC_THIRD:  amp_r[2]          <= cfg_data;
        REG_HARMONIC_FOURTH: amp_r[3]          <= cfg_data;
        default: ;  // unused indexes drop the write
      endcase
    end
  end

  // row of cells, one per harmonic
  fsd_tok_t chain [NUM_HARMONICS+1];
  logic     en;
  logic     out_valid_r;
  logic [RESULT_W-1:0] field_r;
  logic     overflow_r;

  assign en            = !out_valid_r || out_chan.ready || !chain[NUM_HARMONICS].v;
  assign in_chan.ready = en && rst_n;

  always_comb begin
    chain[0].v     = in_chan.valid && en;
    chain[0].pos   = in_chan.axial_position;
    chain[0].order = in_chan.derivative_order;
    chain[0].acc   = '0;
    chain[0].over  = 1'b0;
  end

  for (genvar h = 0; h < NUM_HARMONICS; h++) begin : g_cell
    fsd_cell #(
      .HARM(h + 1), .MAX_ORDER(MAX_ORDER), .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .base_wavenumber(base_wavenumber_r), .phase_step(phase_step_r),
      .amplitude(amp_r[h]), .tok_i(chain[h]), .tok_o(chain[h+1])
    );
  end

  // saturation and output register
  fsd_tok_t last;
  logic     fits, big_order, sat;
  assign last      = chain[NUM_HARMONICS];
  assign fits      = (last.acc[ACC_W-1:RESULT_W-1] == '0) ||
                     (last.acc[ACC_W-1:RESULT_W-1] == '1);
  assign big_order = int'(last.order) > MAX_ORDER;
  assign sat       = last.over || !fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && last.v) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last.v) begin
      if (big_order) begin
        field_r    <= '0;
        overflow_r <= 1'b0;
      end else if (sat) begin
        field_r    <= last.acc[ACC_W-1] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                        : {1'b0, {(RESULT_W-1){1'b1}}};
        overflow_r <= 1'b1;
      end else begin
        field_r    <= last.acc[RESULT_W-1:0];
        overflow_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.field_derivative = field_r;
  assign out_chan.overflow         = overflow_r;

endmodule

// ===== hw/rtl/fsd_checker.sv =====
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks on the derivative evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module fsd_checker import fsd_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [RESULT_W-1:0] field_derivative,
  input logic                overflow
);

  logic [15:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 16'(in_valid && in_ready) - 16'(out_valid && out_ready);
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> pend_r != 16'd0)
    else $error("result transfer with no item in flight");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |->
      field_derivative == {1'b0, {(RESULT_W-1){1'b1}}} ||
      field_derivative == {1'b1, {(RESULT_W-1){1'b0}}})
    else $error("overflow set on an unsaturated value");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(field_derivative))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fourier_series_derivative_core fsd_checker u_fsd_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_chan.valid), .in_ready(in_chan.ready),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .field_derivative(out_chan.field_derivative), .overflow(out_chan.overflow)
);
